// ----- sv/y2r_pkg.sv -----
// shared types and constants for the yuv to rgb pixel converter
`default_nettype none

package y2r_pkg;

    localparam int SUM_W       = 11;
    localparam int GAMMA_W     = 8;
    localparam int GAMMA_DEPTH = 256;
    localparam int PIXEL_W     = 32;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 72;
    localparam int NUM_COLOURS = 3;

    localparam logic OP_GAMMA   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [1:0] CFG_RED_MASK    = 2'd0;
    localparam logic [1:0] CFG_GREEN_MASK  = 2'd1;
    localparam logic [1:0] CFG_BLUE_MASK   = 2'd2;
    localparam logic [1:0] CFG_PIXEL_BYTES = 2'd3;

    localparam int COL_RED   = 0;
    localparam int COL_GREEN = 1;
    localparam int COL_BLUE  = 2;

    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_3 = 3'd3;

    localparam logic [31:0] RESET_RED_MASK   = 32'h0000_F800;
    localparam logic [31:0] RESET_GREEN_MASK = 32'h0000_07E0;
    localparam logic [31:0] RESET_BLUE_MASK  = 32'h0000_001F;
    localparam logic [2:0]  RESET_PIXEL_BYTES = BYTES_2;

    typedef struct packed {
        logic       ok;
        logic [2:0] rsh;
        logic [4:0] lsh;
    } mask_info_t;

endpackage

`default_nettype wire

// ----- sv/y2r_ram.sv -----
// generic ram with one write port and two registered read ports
`default_nettype none

module y2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- sv/y2r_mask_dec.sv -----
// colour mask decoder: validity check and gamma shift amounts
`default_nettype none

module y2r_mask_dec
    import y2r_pkg::*;
(
    input  wire logic [31:0] mask,
    output mask_info_t       info
);

    logic [31:0] lowbit;
    logic [32:0] top_sum;
    logic        contig;
    logic [4:0]  lo;
    logic [31:0] shifted;
    logic [3:0]  zeros;

    always_comb
    begin
        lowbit  = mask & (~mask + 32'd1);
        top_sum = {1'b0, mask} + {1'b0, lowbit};
        contig  = (top_sum & (top_sum - 33'd1)) == 33'd0;
        lo      = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (lowbit[i])
            begin
                lo = lo | 5'(i);
            end
        end
        shifted = mask >> lo;
        zeros   = '0;
        for (int i = 0; i < 8; i++)
        begin
            zeros = zeros + {3'b000, !shifted[i]};
        end
        info.ok  = (mask != 32'd0) && contig && (shifted[31:8] == 24'd0);
        info.rsh = zeros[2:0];
        info.lsh = lo;
    end

endmodule

`default_nettype wire

// ----- sv/y2r_colour.sv -----
// one colour field of a pixel from its clamped sum and gamma entry
`default_nettype none

module y2r_colour
    import y2r_pkg::*;
(
    input  wire logic [SUM_W-1:0]   sum,
    input  wire logic [GAMMA_W-1:0] gamma,
    input  wire logic [31:0]        mask,
    input  wire mask_info_t         info,
    output logic      [PIXEL_W-1:0] field
);

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            field = '0;
        end
        else if (sum[SUM_W-2:GAMMA_W] != '0)
        begin
            field = mask;
        end
        else
        begin
            field = PIXEL_W'(gamma >> info.rsh) << info.lsh;
        end
    end

endmodule

`default_nettype wire

// ----- sv/yuv_to_rgb_pixel_converter_unit.sv -----
// top level of the yuv to rgb pixel converter
//
// s_* channel: one transaction is a pixel pair to convert (s_tuser = 1) or a
// gamma table write (s_tuser = 0). m_* channel: one transaction per input,
// holding both packed pixels, the second-pixel flag and the mask error flag.
// cfg_* channel: register writes (red, green, blue mask, pixel bytes), always
// ready; write only while no transaction is in flight.
// an accepted input passes the input, product, sum and output registers before m_tvalid.
// throughput: one transaction per cycle while m_tready holds high, set by the single pass through the
// multiplier stage, the sum stage and the gamma ram read stage.
// the gamma table is three ram copies, one per colour, each read for both
// pixels in the same cycle; a write lands in all three.
// at reset the masks return to 565 layout, 2 bytes per pixel, and the pipeline
// empties; gamma entries hold nothing until written.
// when m_tready is low the result holds; bubbles in the pipeline still fill,
// so s_tready drops only once all four stages hold a transaction.
`default_nettype none

module yuv_to_rgb_pixel_converter_unit
    import y2r_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // y_first, y_second, u, v, pair_full, gamma_index, gamma_value, zero fill
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_first, pixel_second, second_valid, mask_error, zero fill
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int COEF_W = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 9;

    localparam longint ONE     = 64'sd1 <<< FRAC_BITS;
    localparam longint VR_MAG  = (1596 * ONE) / 1164;
    localparam longint UG_MAG  = (391 * ONE) / 1164;
    localparam longint VG_MAG  = (813 * ONE) / 1164;
    localparam longint UB_MAG  = (2018 * ONE) / 1164;
    localparam longint OFS_R   = (VR_MAG * 128) >>> FRAC_BITS;
    localparam longint OFS_B   = (UB_MAG * 128) >>> FRAC_BITS;
    localparam longint OFS_G   = ((UG_MAG + VG_MAG) * 128 + ONE - 1) >>> FRAC_BITS;

    localparam logic [COEF_W-1:0] COEF_VR = COEF_W'(VR_MAG);
    localparam logic [COEF_W-1:0] COEF_UG = COEF_W'(UG_MAG);
    localparam logic [COEF_W-1:0] COEF_VG = COEF_W'(VG_MAG);
    localparam logic [COEF_W-1:0] COEF_UB = COEF_W'(UB_MAG);
    localparam logic [PROD_W:0]   ROUND_UP = (PROD_W + 1)'(ONE - 1);

    // configuration
    logic [31:0]  mask_reg [NUM_COLOURS];
    logic [2:0]   pixel_bytes_reg;
    mask_info_t   info_next [NUM_COLOURS];
    mask_info_t   info_reg  [NUM_COLOURS];
    logic         all_ok;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready2, ready3, ready4;

    // stage 1: input register
    logic         op_s1_reg;
    logic [7:0]   y0_s1_reg, y1_s1_reg, u_s1_reg, v_s1_reg;
    logic         pf_s1_reg;
    logic [7:0]   gi_s1_reg, gv_s1_reg;

    // stage 2: products
    logic              op_s2_reg;
    logic [7:0]        y0_s2_reg, y1_s2_reg;
    logic              pf_s2_reg;
    logic [7:0]        gi_s2_reg, gv_s2_reg;
    logic [PROD_W-1:0] prod_r_next, prod_gu_next, prod_gv_next, prod_b_next;
    logic [PROD_W-1:0] prod_r_reg, prod_gu_reg, prod_gv_reg, prod_b_reg;
    logic [PROD_W:0]   green_acc;
    logic [SUM_W-1:0]  term [NUM_COLOURS];
    logic [SUM_W-1:0]  sum_first_next  [NUM_COLOURS];
    logic [SUM_W-1:0]  sum_second_next [NUM_COLOURS];
    logic              gamma_we;

    // stage 3: sums and gamma read
    logic              op_s3_reg;
    logic              pf_s3_reg;
    logic [SUM_W-1:0]  sum_first_reg  [NUM_COLOURS];
    logic [SUM_W-1:0]  sum_second_reg [NUM_COLOURS];
    logic [GAMMA_W-1:0] gam_first  [NUM_COLOURS];
    logic [GAMMA_W-1:0] gam_second [NUM_COLOURS];
    logic [PIXEL_W-1:0] field_first  [NUM_COLOURS];
    logic [PIXEL_W-1:0] field_second [NUM_COLOURS];
    logic [PIXEL_W-1:0] pix_first_raw, pix_second_raw, cut_mask;
    logic [PIXEL_W-1:0] pix_first_next, pix_second_next;
    logic               second_valid_next, mask_error_next, convert_ok;

    // stage 4: output register
    logic [PIXEL_W-1:0] pix_first_reg, pix_second_reg;
    logic               second_valid_reg, mask_error_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[COL_RED]   <= RESET_RED_MASK;
            mask_reg[COL_GREEN] <= RESET_GREEN_MASK;
            mask_reg[COL_BLUE]  <= RESET_BLUE_MASK;
            pixel_bytes_reg     <= RESET_PIXEL_BYTES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RED_MASK:    mask_reg[COL_RED]   <= cfg_data;
                CFG_GREEN_MASK:  mask_reg[COL_GREEN] <= cfg_data;
                CFG_BLUE_MASK:   mask_reg[COL_BLUE]  <= cfg_data;
                CFG_PIXEL_BYTES: pixel_bytes_reg     <= cfg_data[2:0];
                default:         pixel_bytes_reg     <= pixel_bytes_reg;
            endcase
        end
    end

    assign ready4   = !v4_reg || m_tready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign s_tready = !v1_reg || ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign prod_r_next  = PROD_W'(v_s1_reg) * PROD_W'(COEF_VR);
    assign prod_gu_next = PROD_W'(u_s1_reg) * PROD_W'(COEF_UG);
    assign prod_gv_next = PROD_W'(v_s1_reg) * PROD_W'(COEF_VG);
    assign prod_b_next  = PROD_W'(u_s1_reg) * PROD_W'(COEF_UB);

    always_comb
    begin
        green_acc = {1'b0, prod_gu_reg} + {1'b0, prod_gv_reg} + ROUND_UP;
        term[COL_RED]   = SUM_W'(prod_r_reg >> FRAC_BITS) - SUM_W'(OFS_R);
        term[COL_GREEN] = SUM_W'(OFS_G) - SUM_W'(green_acc >> FRAC_BITS);
        term[COL_BLUE]  = SUM_W'(prod_b_reg >> FRAC_BITS) - SUM_W'(OFS_B);
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            sum_first_next[c]  = SUM_W'(y0_s2_reg) + term[c];
            sum_second_next[c] = SUM_W'(y1_s2_reg) + term[c];
        end
    end

    assign gamma_we = v2_reg && (op_s2_reg == OP_GAMMA) && ready3;

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_s1_reg <= s_tuser;
            y0_s1_reg <= s_tdata[7:0];
            y1_s1_reg <= s_tdata[15:8];
            u_s1_reg  <= s_tdata[23:16];
            v_s1_reg  <= s_tdata[31:24];
            pf_s1_reg <= s_tdata[32];
            gi_s1_reg <= s_tdata[40:33];
            gv_s1_reg <= s_tdata[48:41];
        end
        if (ready2 && v1_reg)
        begin
            op_s2_reg   <= op_s1_reg;
            y0_s2_reg   <= y0_s1_reg;
            y1_s2_reg   <= y1_s1_reg;
            pf_s2_reg   <= pf_s1_reg;
            gi_s2_reg   <= gi_s1_reg;
            gv_s2_reg   <= gv_s1_reg;
            prod_r_reg  <= prod_r_next;
            prod_gu_reg <= prod_gu_next;
            prod_gv_reg <= prod_gv_next;
            prod_b_reg  <= prod_b_next;
        end
        if (ready3 && v2_reg)
        begin
            op_s3_reg <= op_s2_reg;
            pf_s3_reg <= pf_s2_reg;
            for (int c = 0; c < NUM_COLOURS; c++)
            begin
                sum_first_reg[c]  <= sum_first_next[c];
                sum_second_reg[c] <= sum_second_next[c];
            end
        end
        if (ready4 && v3_reg)
        begin
            pix_first_reg    <= pix_first_next;
            pix_second_reg   <= pix_second_next;
            second_valid_reg <= second_valid_next;
            mask_error_reg   <= mask_error_next;
        end
    end

    for (genvar c = 0; c < NUM_COLOURS; c++)
    begin : g_colour
        y2r_mask_dec u_mask_dec (
            .mask (mask_reg[c]),
            .info (info_next[c])
        );

        always_ff @(posedge clk)
        begin
            info_reg[c] <= info_next[c];
        end

        y2r_ram #(
            .WIDTH (GAMMA_W),
            .DEPTH (GAMMA_DEPTH)
        ) u_gamma_ram (
            .clk     (clk),
            .we      (gamma_we),
            .waddr   (gi_s2_reg),
            .wdata   (gv_s2_reg),
            .re      (ready3),
            .raddr_a (sum_first_next[c][GAMMA_W-1:0]),
            .raddr_b (sum_second_next[c][GAMMA_W-1:0]),
            .rdata_a (gam_first[c]),
            .rdata_b (gam_second[c])
        );

        y2r_colour u_colour_first (
            .sum   (sum_first_reg[c]),
            .gamma (gam_first[c]),
            .mask  (mask_reg[c]),
            .info  (info_reg[c]),
            .field (field_first[c])
        );

        y2r_colour u_colour_second (
            .sum   (sum_second_reg[c]),
            .gamma (gam_second[c]),
            .mask  (mask_reg[c]),
            .info  (info_reg[c]),
            .field (field_second[c])
        );
    end

    assign all_ok = info_reg[COL_RED].ok && info_reg[COL_GREEN].ok && info_reg[COL_BLUE].ok;

    always_comb
    begin
        pix_first_raw  = field_first[COL_RED] | field_first[COL_GREEN] | field_first[COL_BLUE];
        pix_second_raw = field_second[COL_RED] | field_second[COL_GREEN]
                       | field_second[COL_BLUE];
        if (pixel_bytes_reg <= BYTES_2)
        begin
            cut_mask = 32'h0000_FFFF;
        end
        else if (pixel_bytes_reg == BYTES_3)
        begin
            cut_mask = 32'h00FF_FFFF;
        end
        else
        begin
            cut_mask = 32'hFFFF_FFFF;
        end
        convert_ok        = (op_s3_reg == OP_CONVERT) && all_ok;
        second_valid_next = (op_s3_reg == OP_CONVERT) && pf_s3_reg;
        mask_error_next   = !all_ok;
        pix_first_next    = convert_ok ? (pix_first_raw & cut_mask) : '0;
        pix_second_next   = (convert_ok && pf_s3_reg) ? (pix_second_raw & cut_mask) : '0;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {(OUT_DATA_W - 2 * PIXEL_W - 2)'(0), mask_error_reg, second_valid_reg,
                       pix_second_reg, pix_first_reg};

endmodule

`default_nettype wire

// ----- sv/y2r_checker.sv -----
// port-level checks for the yuv to rgb pixel converter, bound to the top level
`default_nettype none

module y2r_checker
    import y2r_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // accepted transaction reaches m_tvalid when m_tready stays high behind it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

    // absent second pixel is zero
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[64]) |-> (m_tdata[63:32] == 32'd0))
        else $error("second pixel nonzero while not valid");

    // bad mask zeroes both pixels
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65]) |-> (m_tdata[63:0] == 64'd0))
        else $error("pixels nonzero with mask error");

endmodule

bind yuv_to_rgb_pixel_converter_unit y2r_checker u_y2r_checker (.*);

`default_nettype wire
